// File: design/wpl_pkg.sv
// Shared types and constants for the window pattern locator.
`timescale 1ns / 1ps
package wpl_pkg;

  localparam int BYTE_W          = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int PLEN_W          = 4;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_WINDOW_DEF  = 65536;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PATTERN_BYTES  = 2'd0;
  localparam cfg_index_t REG_PATTERN_LENGTH = 2'd1;
  localparam cfg_index_t REG_SEARCH_MODE    = 2'd2;

  typedef enum logic [1:0] {
    MODE_FIRST        = 2'd0,
    MODE_LAST         = 2'd1,
    MODE_ANCHOR_START = 2'd2,
    MODE_ANCHOR_END   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [PLEN_W-1:0] len;
    mode_t             mode;
  } search_cfg_t;

endpackage

// File: design/wpl_cell.sv
// History cell: compares its incoming window byte with its pattern byte and holds that byte for the next cell.
`timescale 1ns / 1ps
module wpl_cell
  import wpl_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int AGE         = 0
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [BYTE_W-1:0]             byte_in,
  input  logic [BYTE_W*MAX_PATTERN-1:0] pattern,
  input  logic [PLEN_W-1:0]             len,
  output logic [BYTE_W-1:0]             byte_out,
  output logic                          hit
);

  logic              active;
  logic [PLEN_W-1:0] pidx;
  logic [BYTE_W-1:0] pbyte;

  assign active = len > PLEN_W'(AGE);
  assign pidx   = len - PLEN_W'(AGE) - PLEN_W'(1);

  always_comb begin
    pbyte = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (pidx == PLEN_W'(j)) begin
        pbyte = pattern[BYTE_W*j +: BYTE_W];
      end
    end
  end

  assign hit = !active || (byte_in == pbyte);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_out <= byte_in;
    end
  end

endmodule

// File: design/wpl_tracker.sv
// Window byte count, match start tracking and result selection.
`timescale 1ns / 1ps
module wpl_tracker
  import wpl_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
  parameter int POS_W      = $clog2(MAX_WINDOW + 2)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             final_byte,
  input  logic             match,
  input  search_cfg_t      cfg,
  output logic             shift_en,
  output logic             found,
  output logic [POS_W-1:0] position
);

  logic [CNT_W-1:0] count, count_next, count_inc, len_ext, start;
  logic [CNT_W-1:0] first_start, first_start_next;
  logic [CNT_W-1:0] last_start, last_start_next;
  logic             counting, hit_ok;

  assign counting  = count < CNT_W'(MAX_WINDOW);
  assign shift_en  = take && counting;
  assign count_inc = count + CNT_W'(1);
  assign len_ext   = CNT_W'(cfg.len);
  assign hit_ok    = (cfg.len != '0) && (count_inc >= len_ext) && match;
  assign start     = count_inc - len_ext + CNT_W'(1);

  always_comb begin
    count_next       = count;
    first_start_next = first_start;
    last_start_next  = last_start;
    if (counting) begin
      count_next = count_inc;
      if (hit_ok) begin
        last_start_next = start;
        if (first_start == '0) begin
          first_start_next = start;
        end
      end
    end
  end

  always_comb begin
    found    = 1'b0;
    position = '0;
    if (cfg.len == '0) begin
      found = 1'b1;
      if (cfg.mode == MODE_FIRST || cfg.mode == MODE_ANCHOR_START) begin
        position = POS_W'(1);
      end else begin
        position = POS_W'(count_next) + POS_W'(1);
      end
    end else begin
      unique case (cfg.mode)
        MODE_FIRST: begin
          found    = first_start_next != '0;
          position = POS_W'(first_start_next);
        end
        MODE_LAST: begin
          found    = last_start_next != '0;
          position = POS_W'(last_start_next);
        end
        MODE_ANCHOR_START: begin
          if (first_start_next == CNT_W'(1)) begin
            found    = 1'b1;
            position = POS_W'(cfg.len) + POS_W'(1);
          end
        end
        MODE_ANCHOR_END: begin
          if (last_start_next != '0 && count_next >= len_ext &&
              last_start_next == count_next - len_ext + CNT_W'(1)) begin
            found    = 1'b1;
            position = POS_W'(last_start_next);
          end
        end
        default: begin
          found    = 1'b0;
          position = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      first_start <= '0;
      last_start  <= '0;
    end else if (take) begin
      if (final_byte) begin
        count       <= '0;
        first_start <= '0;
        last_start  <= '0;
      end else begin
        count       <= count_next;
        first_start <= first_start_next;
        last_start  <= last_start_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WINDOW))
    else $error("byte count beyond window limit");

  a_first_before_last: assert property (@(posedge clk) disable iff (rst)
    first_start != '0 |-> last_start >= first_start && last_start != '0)
    else $error("first match start after last match start");

  a_start_in_window: assert property (@(posedge clk) disable iff (rst)
    last_start <= count)
    else $error("match start beyond byte count");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    take && final_byte |=> count == '0 && first_start == '0 && last_start == '0)
    else $error("window state not cleared after final byte");
`endif

endmodule

// File: design/window_pattern_locator_top.sv
// Top level of the window pattern locator: config, cell chain, tracker, output register.
// A final byte's result is valid in the cycle after its request is accepted.
// Throughput: one byte per cycle; the cell chain compares the pattern in parallel.
// A waiting result stalls input only until out_ready takes it.
// Reset (rst, synchronous): clears config, byte count, match starts and out_valid.
`timescale 1ns / 1ps
module window_pattern_locator_top
  import wpl_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int POS_W       = $clog2(MAX_WINDOW + 2)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      text_byte,
  input  logic                   final_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [POS_W-1:0]       position
);

  logic [BYTE_W*MAX_PATTERN-1:0] pattern;
  logic [PLEN_W-1:0]             pattern_length;
  mode_t                         search_mode;
  search_cfg_t                   cfg;
  logic                          take, shift_en, match, found_next;
  logic [POS_W-1:0]              position_next;
  logic [BYTE_W-1:0]             links [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]        hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= '0;
      search_mode    <= MODE_FIRST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pattern        <= cfg_data[BYTE_W*MAX_PATTERN-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        REG_SEARCH_MODE:    search_mode    <= mode_t'(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg.len  = (pattern_length > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
                                                            : pattern_length;
  assign cfg.mode = search_mode;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign links[0] = text_byte;

  for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
    if (a < MAX_PATTERN - 1) begin : g_mid
      wpl_cell #(.MAX_PATTERN(MAX_PATTERN), .AGE(a)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .byte_in  (links[a]),
        .pattern  (pattern),
        .len      (cfg.len),
        .byte_out (links[a+1]),
        .hit      (hits[a])
      );
    end else begin : g_end
      wpl_cell #(.MAX_PATTERN(MAX_PATTERN), .AGE(a)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .byte_in  (links[a]),
        .pattern  (pattern),
        .len      (cfg.len),
        .byte_out (),
        .hit      (hits[a])
      );
    end
  end

  assign match = &hits;

  wpl_tracker #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      ($clog2(MAX_WINDOW + 1)),
    .POS_W      (POS_W)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .final_byte (final_byte),
    .match      (match),
    .cfg        (cfg),
    .shift_en   (shift_en),
    .found      (found_next),
    .position   (position_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && final_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && final_byte) begin
      found    <= found_next;
      position <= position_next;
    end
  end

endmodule
